### hw/rtl/scsf_pkg.sv
// scsf_pkg: shared constants for the settings slot crc16 fixer
// slot offsets, crc polynomial and seed; no dependencies
`default_nettype none

package scsf_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W  = 16;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CRC_W-1:0]  crc_t;

    // reflected crc-16, no final xor
    localparam crc_t CRC_POLY = 16'hA001;
    localparam crc_t CRC_SEED = 16'hFFFF;

    // slot layout offsets
    localparam byte_t REGION1_END   = 8'h70;
    localparam byte_t CRC1_LO       = 8'h72;
    localparam byte_t CRC1_HI       = 8'h73;
    localparam byte_t REGION2_START = 8'h74;
    localparam byte_t CRC2_LO       = 8'hFE;
    localparam byte_t CRC2_HI       = 8'hFF;

endpackage

`default_nettype wire

### hw/rtl/scsf_crc_step.sv
// scsf_crc_step: one-byte update of the reflected crc-16
// eight unrolled shift-xor steps; uses scsf_pkg
`default_nettype none

module scsf_crc_step (
    input  wire scsf_pkg::crc_t  crc_in,
    input  wire scsf_pkg::byte_t data_in,
    output scsf_pkg::crc_t       crc_out
);
    import scsf_pkg::*;

    // bitwise lsb-first division by the reflected polynomial
    always_comb begin
        crc_t c;
        c = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

### hw/rtl/settings_slot_crc16_fixer_top.sv
// settings_slot_crc16_fixer_top: byte stream crc fixer for 256-byte settings slots
// uses scsf_pkg and scsf_crc_step
`default_nettype none

// Usage
//   s_ channel: one slot byte per transaction, in address order; slots follow
//   each other back to back, the offset counter wraps after offset 0xFF.
//   m_ channel: one transaction per input byte: the byte itself, or the crc
//   byte at offsets 0x72/0x73 (crc of 0x00-0x6F, low byte first) and 0xFE/0xFF
//   (crc of 0x74-0xFD). m_slot_end marks offset 0xFF.
//   Pipeline: an accepted byte passes through the input register, then the
//   result register fed by the one-byte crc update.
//   Throughput: one byte per cycle while m_ready stays high; the crc update
//   is a single eight-step shift-xor between the input register and the
//   result register.
//   Stall: while m_ready is low the result holds; one more byte waits in the
//   input register, after which s_ready drops.
//   Reset (aresetn low, synchronous): both stages empty, offset returns to 0
//   and the crc to 0xFFFF.

module settings_slot_crc16_fixer_top (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire scsf_pkg::byte_t  s_slot_byte,
    output logic                  m_valid,
    input  wire                   m_ready,
    output scsf_pkg::byte_t       m_fixed_byte,
    output logic                  m_slot_end
);
    import scsf_pkg::*;

    logic  in_valid_reg;
    byte_t in_byte_reg;
    byte_t pos_reg, pos_next;
    crc_t  crc_reg, crc_next;
    logic  out_valid_reg;
    byte_t out_byte_reg, out_byte_next;
    logic  out_end_reg, out_end_next;
    crc_t  crc_upd;
    logic  advance;

    // move from input register to result register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    scsf_crc_step u_crc_step (
        .crc_in  (crc_reg),
        .data_in (in_byte_reg),
        .crc_out (crc_upd)
    );

    // offset decode, crc bookkeeping and byte replacement
    always_comb begin
        pos_next      = pos_reg + 8'd1;
        crc_next      = crc_reg;
        out_byte_next = in_byte_reg;
        out_end_next  = 1'b0;
        if (pos_reg < REGION1_END) begin
            crc_next = crc_upd;
        end else if (pos_reg == CRC1_LO || pos_reg == CRC2_LO) begin
            out_byte_next = crc_reg[7:0];
        end else if (pos_reg == CRC1_HI || pos_reg == CRC2_HI) begin
            out_byte_next = crc_reg[15:8];
            crc_next      = CRC_SEED;
            out_end_next  = (pos_reg == CRC2_HI);
        end else if (pos_reg >= REGION2_START) begin
            crc_next = crc_upd;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_byte_reg <= s_slot_byte;
        end
    end

    // slot state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            crc_reg <= CRC_SEED;
        end else if (advance) begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_byte_reg <= out_byte_next;
            out_end_reg  <= out_end_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_fixed_byte = out_byte_reg;
    assign m_slot_end   = out_end_reg;

endmodule

`default_nettype wire

### hw/rtl/scsf_checker.sv
// scsf_checker: port-level assertions for settings_slot_crc16_fixer_top
// uses scsf_pkg; bound to the top level at the end of this file
`default_nettype none

module scsf_checker (
    input wire                  aclk,
    input wire                  aresetn,
    input wire                  s_valid,
    input wire                  s_ready,
    input wire scsf_pkg::byte_t s_slot_byte,
    input wire                  m_valid,
    input wire                  m_ready,
    input wire scsf_pkg::byte_t m_fixed_byte,
    input wire                  m_slot_end
);
    import scsf_pkg::*;

    byte_t      out_cnt_reg;
    logic [1:0] occ_reg;
    logic       in_xact, out_xact;

    assign in_xact  = s_valid && s_ready;
    assign out_xact = m_valid && m_ready;

    // output transaction count within the slot, and items in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_cnt_reg <= '0;
            occ_reg     <= '0;
        end else begin
            if (out_xact) begin
                out_cnt_reg <= out_cnt_reg + 8'd1;
            end
            occ_reg <= occ_reg + {1'b0, in_xact} - {1'b0, out_xact};
        end
    end

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // slot end marks exactly every 256th result
    a_slot_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_slot_end == (out_cnt_reg == CRC2_HI)))
        else $error("slot end misplaced");

    // at most two transactions in flight, and back-pressure only when both stages are full
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        (occ_reg != 2'd3) && (s_ready || (occ_reg == 2'd2 && m_valid)))
        else $error("occupancy out of range");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fixed_byte) && $stable(m_slot_end))
        else $error("stalled result changed");

    // waiting input transaction holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_slot_byte))
        else $error("waiting input changed");

endmodule

bind settings_slot_crc16_fixer_top scsf_checker u_scsf_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_slot_byte  (s_slot_byte),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_fixed_byte (m_fixed_byte),
    .m_slot_end   (m_slot_end)
);

`default_nettype wire
